// ----- hw/rtl/tvm_pkg.sv -----
// shared types, codes and tables of the triangle voice effect mixer
package tvm_pkg;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_MIX   = 1'b1;

    // field widths
    localparam int PHASE_W = 32;
    localparam int EFF_W   = 3;
    localparam int REM_W   = 12;
    localparam int GAIN_W  = 12;
    localparam int ENV_W   = 9;
    localparam int TRI_W   = 16;
    localparam int SUM_W   = 20;
    localparam int TG_W    = TRI_W + GAIN_W + 1;
    localparam int PROD_W  = TG_W + ENV_W + 1;
    localparam int SCALE_SH = 23;

    // effect ids that start a synth voice
    localparam logic [3:0] EFF_FIRST = 4'd1;
    localparam logic [3:0] EFF_LAST  = 4'd6;

    // level and gain scaling
    localparam logic [16:0] LEVEL_ONE = 17'd65536;
    localparam logic [28:0] GAIN_MAX  = 29'd2200;

    // attack length of the envelope
    localparam logic [REM_W-1:0] ATTACK_LEN = 12'd32;

    // triangle fold point
    localparam logic signed [17:0] TRI_TOP = 18'sd98303;
    localparam logic signed [17:0] TRI_MID = 18'sd32768;

    // phase step per effect, freq * 2^32 / 16000
    localparam logic [PHASE_W-1:0] STEP_TAB [8] = '{
        32'd0,
        32'((64'd1200 << 32) / 64'd16000),
        32'((64'd850  << 32) / 64'd16000),
        32'((64'd1700 << 32) / 64'd16000),
        32'((64'd520  << 32) / 64'd16000),
        32'((64'd2300 << 32) / 64'd16000),
        32'((64'd920  << 32) / 64'd16000),
        32'd0
    };

    // voice duration per effect in samples
    localparam logic [REM_W-1:0] LEN_TAB [8] = '{
        12'd0, 12'd640, 12'd240, 12'd1200, 12'd1600, 12'd2400, 12'd2240, 12'd0
    };

    // input request
    typedef struct packed {
        logic               command;
        logic [3:0]         effect_id;
        logic [16:0]        level;
        logic signed [15:0] sample_in;
    } t_in_item;

    // output request
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               any_active;
    } t_out_item;

    // one voice entry of the state memory
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [EFF_W-1:0]   effect;
        logic [REM_W-1:0]   remaining;
        logic [REM_W-1:0]   length;
        logic [GAIN_W-1:0]  gain;
    } t_voice;

endpackage

// ----- hw/rtl/tvm_voice_ram.sv -----
// voice state memory, one read and one write port, registered read data
module tvm_voice_ram
    import tvm_pkg::*;
#(
    parameter int VOICES = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] i_waddr,
    input  t_voice                                i_wdata,
    input  logic                                  i_re,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] i_raddr,
    output t_voice                                o_rdata
);

    t_voice             r_mem [VOICES];
    logic [VOICES-1:0]  r_vld;
    t_voice             r_rdata;

    // entry valid bits, an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // memory array write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tvm_env_div.sv -----
// bit-serial envelope divider, remaining * 256 / length, one quotient bit a cycle
module tvm_env_div
    import tvm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REM_W-1:0] i_rem,
    input  logic [REM_W-1:0] i_len,
    output logic             o_done,
    output logic [ENV_W-1:0] o_env
);

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [REM_W-1:0] r_part;
    logic [REM_W-1:0] r_len;
    logic [ENV_W-1:0] r_shift;
    logic [ENV_W-1:0] r_quo;

    logic [REM_W:0]   w_trial;
    logic             w_fit;

    // shift in the next dividend bit and try the subtract
    assign w_trial = {r_part, r_shift[ENV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_len});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(ENV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, dividend is {rem, 8 zeros}, the upper part seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_part  <= {1'b0, i_rem[REM_W-1:1]};
            r_shift <= {i_rem[0], {(ENV_W-1){1'b0}}};
            r_len   <= i_len;
            r_quo   <= '0;
        end else if (r_busy) begin
            r_part  <= w_fit ? REM_W'(w_trial - {1'b0, r_len}) : w_trial[REM_W-1:0];
            r_shift <= {r_shift[ENV_W-2:0], 1'b0};
            r_quo   <= {r_quo[ENV_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_env  = r_quo;

endmodule

// ----- hw/rtl/triangle_voice_effect_mixer.sv -----
// Three-voice triangle effect mixer, top level with sequencer and mix datapath.
// A start request leaves the sequencer idle; requests may follow back to back.
// A mix request reads each voice in turn and runs the envelope divider for each live
// voice; the envelope divider sets most of the time a mix request takes.
// One mix request is worked on at a time; the result register lets the next one in.
// Synchronous active-low reset: all voices idle, round-robin pointer at voice 0.
module triangle_voice_effect_mixer
    import tvm_pkg::*;
#(
    parameter int VOICES = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_LOAD = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MUL1 = 8'b0001_0000,
        S_MUL2 = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_vidx, n_vidx;
    logic [AW-1:0]             r_next, n_next;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic                      r_live, n_live;
    logic                      r_out_valid;
    t_out_item                 r_out;
    t_voice                    r_cur;
    logic signed [TG_W-1:0]    r_tg;
    logic [ENV_W-1:0]          r_env;
    logic signed [PROD_W-1:0]  r_prod;

    logic                      w_accept;
    logic                      w_start_ok;
    logic                      w_last;
    logic [16:0]               w_level;
    logic [28:0]               w_gain_full;
    t_voice                    w_start_word;
    t_voice                    w_rd;
    t_voice                    w_adv;
    t_voice                    w_wb;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    t_voice                    w_wdata;
    logic                      w_re;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [ENV_W-1:0]          w_div_q;
    logic [15:0]               w_p;
    logic signed [17:0]        w_tri_x;
    logic signed [TRI_W-1:0]   w_tri;
    logic signed [TG_W-1:0]    w_tg;
    logic [REM_W-1:0]          w_age;
    logic [ENV_W-1:0]          w_env_raw;
    logic [12:0]               w_env_att;
    logic [ENV_W-1:0]          w_env;
    logic signed [PROD_W-1:0]  w_bias;
    logic signed [PROD_W-1:0]  w_contrib;
    logic signed [15:0]        w_sat;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = (r_vidx == AW'(VOICES - 1));

    // start request decode and gain, 2200 * clamped level / 65536
    assign w_start_ok  = (i_in.command == CMD_START) && (i_in.effect_id >= EFF_FIRST)
                         && (i_in.effect_id <= EFF_LAST);
    assign w_level     = (i_in.level > LEVEL_ONE) ? LEVEL_ONE : i_in.level;
    assign w_gain_full = GAIN_MAX * {12'd0, w_level};

    always_comb begin
        w_start_word           = '0;
        w_start_word.effect    = i_in.effect_id[EFF_W-1:0];
        w_start_word.remaining = LEN_TAB[i_in.effect_id[EFF_W-1:0]];
        w_start_word.length    = LEN_TAB[i_in.effect_id[EFF_W-1:0]];
        w_start_word.gain      = w_gain_full[16 +: GAIN_W];
    end

    // voice read back with its phase advanced by one sample
    always_comb begin
        w_adv       = w_rd;
        w_adv.phase = w_rd.phase + STEP_TAB[w_rd.effect];
    end

    // write back of an advanced voice
    always_comb begin
        w_wb           = r_cur;
        w_wb.remaining = r_cur.remaining - REM_W'(1);
    end

    // memory port selection
    assign w_we    = (w_accept && w_start_ok) || (r_state == S_MUL1);
    assign w_waddr = (r_state == S_MUL1) ? r_vidx : r_next;
    assign w_wdata = (r_state == S_MUL1) ? w_wb : w_start_word;
    assign w_re    = (r_state == S_READ);

    tvm_voice_ram #(
        .VOICES (VOICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_vidx),
        .o_rdata (w_rd)
    );

    assign w_div_start = (r_state == S_LOAD) && (w_rd.remaining != '0);

    tvm_env_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_rd.remaining),
        .i_len   (w_rd.length),
        .o_done  (w_div_done),
        .o_env   (w_div_q)
    );

    // triangle sample from the advanced phase
    assign w_p     = r_cur.phase[PHASE_W-1 -: 16];
    assign w_tri_x = w_p[15] ? (TRI_TOP - $signed({1'b0, w_p, 1'b0}))
                             : ($signed({1'b0, w_p, 1'b0}) - TRI_MID);
    assign w_tri   = w_tri_x[TRI_W-1:0];
    assign w_tg    = w_tri * $signed({1'b0, r_cur.gain});

    // envelope with linear attack
    assign w_age     = (r_cur.length >= r_cur.remaining) ? (r_cur.length - r_cur.remaining)
                                                         : '0;
    assign w_env_raw = (r_cur.length == '0) ? '0 : w_div_q;
    assign w_env_att = 13'(w_env_raw) * 13'(w_age[4:0]);
    assign w_env     = (w_age < ATTACK_LEN) ? ENV_W'(w_env_att >> 5) : w_env_raw;

    // scale by 2^-23 with truncation toward zero
    assign w_bias    = r_prod[PROD_W-1] ? (r_prod + PROD_W'((1 << SCALE_SH) - 1)) : r_prod;
    assign w_contrib = w_bias >>> SCALE_SH;

    // saturate the mixed sum
    always_comb begin
        if (r_sum > SUM_W'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (r_sum < -SUM_W'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = r_sum[15:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_vidx  = r_vidx;
        n_next  = r_next;
        n_sum   = r_sum;
        n_live  = r_live;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.command == CMD_MIX) begin
                        n_sum   = SUM_W'(i_in.sample_in);
                        n_live  = 1'b0;
                        n_vidx  = '0;
                        n_state = S_READ;
                    end else if (w_start_ok) begin
                        n_next = (r_next == AW'(VOICES - 1)) ? '0 : r_next + AW'(1);
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_rd.remaining != '0) begin
                    n_state = S_DIV;
                end else if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_vidx  = r_vidx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum  = r_sum + w_contrib[SUM_W-1:0];
                n_live = r_live || (r_cur.remaining != REM_W'(1));
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_vidx  = r_vidx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vidx      <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vidx  <= n_vidx;
            r_next  <= n_next;
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_live <= n_live;
        if (r_state == S_LOAD) begin
            r_cur <= w_adv;
        end
        if (r_state == S_MUL1) begin
            r_tg  <= w_tg;
            r_env <= w_env;
        end
        if (r_state == S_MUL2) begin
            r_prod <= r_tg * $signed({1'b0, r_env});
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out.sample_out <= w_sat;
            r_out.any_active <= r_live;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hw/rtl/tvm_checker.sv -----
// port checks of the triangle voice effect mixer and their binding
module tvm_checker
    import tvm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // no result is pending right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // a mix request keeps the block busy in the next cycle
    a_mix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.command == CMD_MIX) |=> !o_in_ready)
        else $error("request taken during a mix");

    // a start request produces no result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready && (i_in.command == CMD_START)
        |=> !o_out_valid)
        else $error("result after a start request");

endmodule

bind triangle_voice_effect_mixer tvm_checker u_tvm_checker (.*);

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the triangle voice effect mixer
module testbench;
    import tvm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOICES = 3;

    // tone frequency in Hz and duration in samples per effect id
    localparam longint unsigned TONE_HZ [7] = '{0, 1200, 850, 1700, 520, 2300, 920};
    localparam int DUR_SAMPLES [7] = '{0, 640, 240, 1200, 1600, 2400, 2240};

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    // own copy of the voice state
    logic [31:0] vc_phase  [VOICES];
    logic [2:0]  vc_effect [VOICES];
    logic [11:0] vc_left   [VOICES];
    logic [11:0] vc_len    [VOICES];
    logic [11:0] vc_gain   [VOICES];
    int          rr_next;

    // expected mix results, oldest first
    t_out_item mix_results_due [$];

    int errors;
    int sent_items;
    int starts_taken;
    int mixes_checked;
    int live_results;
    int clip_count;
    int stall_cycles;
    int burst_left;
    int hold_len;

    triangle_voice_effect_mixer #(
        .VOICES(VOICES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // phase increment of one effect
    function automatic logic [31:0] tone_step(input logic [2:0] eff);
        longint unsigned f;
        f = (eff > 3'd6) ? 64'd0 : TONE_HZ[eff];
        return 32'((f << 32) / 64'd16000);
    endfunction

    // start request: claim the next voice in turn
    function automatic void claim_voice(input t_in_item req);
        int lvl;
        if (req.effect_id < EFF_FIRST || req.effect_id > EFF_LAST) begin
            return;
        end
        lvl = (req.level > 17'd65536) ? 65536 : int'(req.level);
        vc_phase[rr_next]  = '0;
        vc_effect[rr_next] = req.effect_id[2:0];
        vc_left[rr_next]   = 12'(DUR_SAMPLES[req.effect_id]);
        vc_len[rr_next]    = 12'(DUR_SAMPLES[req.effect_id]);
        vc_gain[rr_next]   = 12'((2200 * lvl) >> 16);
        rr_next = (rr_next + 1) % VOICES;
        starts_taken++;
    endfunction

    // one triangle sample of a live voice, with decay and attack envelope
    function automatic longint voice_tone(input int v);
        int pv;
        int wave;
        int r;
        int l;
        int env;
        int age;
        vc_phase[v] = vc_phase[v] + tone_step(vc_effect[v]);
        pv = int'(vc_phase[v] >> 16);
        wave = (pv < 32768) ? 2 * pv - 32768 : 98303 - 2 * pv;
        r = int'(vc_left[v]);
        l = int'(vc_len[v]);
        env = (l == 0) ? 0 : (r * 256) / l;
        age = (l >= r) ? l - r : 0;
        if (age < 32) begin
            env = (env * age) / 32;
        end
        vc_left[v] = vc_left[v] - 12'd1;
        return (longint'(wave) * longint'(vc_gain[v]) * longint'(env)) / 64'sd8388608;
    endfunction

    // mix request: add all live voices to the pcm sample and saturate
    function automatic t_out_item mix_sample(input t_in_item req);
        t_out_item res;
        longint sum;
        logic live;
        sum = longint'(req.sample_in);
        live = 1'b0;
        for (int v = 0; v < VOICES; v++) begin
            if (vc_left[v] != '0) begin
                sum += voice_tone(v);
            end
        end
        for (int v = 0; v < VOICES; v++) begin
            if (vc_left[v] != '0) begin
                live = 1'b1;
            end
        end
        if (sum > 32767) begin
            sum = 32767;
            clip_count++;
        end else if (sum < -32768) begin
            sum = -32768;
            clip_count++;
        end
        res.sample_out = 16'(sum);
        res.any_active = live;
        return res;
    endfunction

    // watch both channels: check results, predict accepted requests
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (mix_results_due.size() == 0) begin
                    $display("%0t ns: result with no request pending, got %0d/%0b",
                             $time, o_out.sample_out, o_out.any_active);
                    errors++;
                end else begin
                    want = mix_results_due.pop_front();
                    mixes_checked++;
                    if (want.any_active) begin
                        live_results++;
                    end
                    if (o_out.sample_out !== want.sample_out) begin
                        $display("%0t ns: sample_out expected %0d, got %0d",
                                 $time, want.sample_out, o_out.sample_out);
                        errors++;
                    end
                    if (o_out.any_active !== want.any_active) begin
                        $display("%0t ns: any_active expected %0b, got %0b",
                                 $time, want.any_active, o_out.any_active);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_ready) begin
                stall_cycles++;
            end
            if (i_in_valid && o_in_ready) begin
                if (i_in.command == CMD_MIX) begin
                    mix_results_due.push_back(mix_sample(i_in));
                end else begin
                    claim_voice(i_in);
                end
            end
        end
    end

    // result side: run and stall stretches, plus a long hold on request
    initial begin
        int stretch_left;
        logic stalling;
        i_out_ready = 1'b0;
        stretch_left = 0;
        stalling = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end else begin
                if (stretch_left == 0) begin
                    stalling = ($urandom_range(0, 2) == 0);
                    stretch_left = $urandom_range(8, 64);
                end
                stretch_left--;
                i_out_ready <= stalling ? ($urandom_range(0, 3) == 0) : 1'b1;
            end
        end
    end

    // send one request in bursts with random gaps
    task automatic send_item(input t_in_item item);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
    endtask

    task automatic start_fx(input logic [3:0] eff, input logic [16:0] lvl);
        t_in_item r;
        r.command   = CMD_START;
        r.effect_id = eff;
        r.level     = lvl;
        r.sample_in = 16'($urandom);
        send_item(r);
    endtask

    task automatic mix_pcm(input logic signed [15:0] pcm);
        t_in_item r;
        r.command   = CMD_MIX;
        r.effect_id = 4'($urandom);
        r.level     = 17'($urandom);
        r.sample_in = pcm;
        send_item(r);
    endtask

    // level: mostly in range, sometimes the ends or above one
    function automatic logic [16:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 17'($urandom_range(65537, 131071));
            1: return ($urandom_range(0, 1) == 0) ? 17'd0 : 17'd65536;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // pcm sample: mostly random, sometimes full scale
    function automatic logic signed [15:0] rand_pcm();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // effect id: mostly a synth effect, sometimes one that is ignored
    function automatic logic [3:0] rand_effect();
        int v;
        if ($urandom_range(0, 6) == 0) begin
            v = $urandom_range(7, 16);
            return (v == 16) ? 4'd0 : 4'(v);
        end
        return 4'($urandom_range(1, 6));
    endfunction

    // mixing with no voice live passes the sample through
    task automatic test_idle_mix();
        mix_pcm(16'sh7fff);
        mix_pcm(16'sh8000);
        mix_pcm(16'sh0000);
        mix_pcm(16'($urandom));
    endtask

    // ids outside 1..6 claim no voice
    task automatic test_unknown_ids();
        start_fx(4'd0, 17'd65536);
        start_fx(4'd7, 17'd131071);
        start_fx(4'd15, 17'd40000);
        mix_pcm(16'sh1234);
    endtask

    // every effect, level extremes and clamping, full-scale samples
    task automatic test_every_effect();
        start_fx(4'd1, 17'd0);
        start_fx(4'd2, 17'd65536);
        start_fx(4'd3, 17'd131071);
        mix_pcm(16'sh7fff);
        mix_pcm(16'sh8000);
        start_fx(4'd4, 17'd65537);
        start_fx(4'd5, 17'd32768);
        start_fx(4'd6, 17'd1);
        mix_pcm(16'sh7fff);
        mix_pcm(16'sh8000);
        mix_pcm(16'sh0000);
    endtask

    // short effect on all voices, played through attack, decay and expiry
    task automatic test_voice_expiry();
        repeat (VOICES) start_fx(4'd2, rand_level());
        repeat (250) mix_pcm(rand_pcm());
    endtask

    // long result hold while requests keep coming
    task automatic test_input_stall();
        start_fx(rand_effect(), rand_level());
        hold_len = 300;
        repeat (40) mix_pcm(rand_pcm());
    endtask

    // random starts followed by runs of mixes
    task automatic test_random_traffic();
        while (sent_items < 1150) begin
            repeat ($urandom_range(0, 3)) start_fx(rand_effect(), rand_level());
            repeat ($urandom_range(1, 80)) mix_pcm(rand_pcm());
        end
    endtask

    // limit on the whole run
    initial begin
        #5ms;
        $display("timeout, %0d results still pending", mix_results_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // reset, tests in turn, drain and verdict
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        errors = 0;
        sent_items = 0;
        starts_taken = 0;
        mixes_checked = 0;
        live_results = 0;
        clip_count = 0;
        stall_cycles = 0;
        burst_left = 0;
        hold_len = 0;
        rr_next = 0;
        for (int v = 0; v < VOICES; v++) begin
            vc_phase[v]  = '0;
            vc_effect[v] = '0;
            vc_left[v]   = '0;
            vc_len[v]    = '0;
            vc_gain[v]   = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_mix();
        test_unknown_ids();
        test_every_effect();
        test_voice_expiry();
        test_input_stall();
        test_random_traffic();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mix_results_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("sent %0d requests, %0d voice starts, %0d mixed samples checked",
                 sent_items, starts_taken, mixes_checked);
        $display("%0d results with voices live, %0d saturated, input held %0d cycles",
                 live_results, clip_count, stall_cycles);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
